[rtl/core/brfs_pkg.sv]
// ----------------------------------------------------------------------------
// brfs_pkg
// Shared types and codes of the byte ring FIFO with search: operation and
// status codes, field widths and the control word broadcast to the cells.
// ----------------------------------------------------------------------------
package brfs_pkg;

  // field widths of the item channels
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned AMT_W  = 9;
  localparam int unsigned POS_W  = 8;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned FILL_W = 9;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_PUSH    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP     = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_DISCARD = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_FIND    = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_PEEK    = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

  // control broadcast to every cell of the ring
  typedef struct packed {
    logic              shift;      // rotate toward cell 0
    logic              push;       // write push_byte into the cell at the fill index
    logic [BYTE_W-1:0] push_byte;
  } cell_ctrl_t;

endpackage

[rtl/core/brfs_if.sv]
// ----------------------------------------------------------------------------
// brfs_if
// Valid/ready channels of the byte ring FIFO: command items in, result
// items out.
// ----------------------------------------------------------------------------
interface brfs_in_if;
  logic                          valid;
  logic                          ready;
  logic [brfs_pkg::FUNC_W-1:0]   func;
  logic [brfs_pkg::BYTE_W-1:0]   data_byte;
  logic [brfs_pkg::AMT_W-1:0]    amount;
  logic [brfs_pkg::POS_W-1:0]    position;

  modport source (output valid, func, data_byte, amount, position, input ready);
  modport sink   (input valid, func, data_byte, amount, position, output ready);
endinterface

interface brfs_out_if;
  logic                          valid;
  logic                          ready;
  logic [brfs_pkg::STAT_W-1:0]   status;
  logic [brfs_pkg::BYTE_W-1:0]   data_out;
  logic [brfs_pkg::POS_W-1:0]    found_position;
  logic [brfs_pkg::FILL_W-1:0]   fill_level;
  logic                          last;

  modport source (output valid, status, data_out, found_position, fill_level, last,
                  input ready);
  modport sink   (input valid, status, data_out, found_position, fill_level, last,
                  output ready);
endinterface

[rtl/core/brfs_cell.sv]
// ----------------------------------------------------------------------------
// brfs_cell
// One byte cell of the ring. Takes its neighbor's byte on a rotate, or the
// pushed byte when the fill index points at this cell.
// ----------------------------------------------------------------------------
module brfs_cell #(
  parameter int unsigned AW  = 8,
  parameter int unsigned IDX = 0
) (
  input  logic                        clk_i,
  input  brfs_pkg::cell_ctrl_t        ctrl_i,
  input  logic [AW-1:0]               wr_idx_i,
  input  logic [brfs_pkg::BYTE_W-1:0] nbr_i,
  output logic [brfs_pkg::BYTE_W-1:0] data_o
);

  logic [brfs_pkg::BYTE_W-1:0] data_q;
  logic                        wr_sel;

  // this cell is the first free slot
  assign wr_sel = ctrl_i.push && (wr_idx_i == AW'(IDX));

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    if (wr_sel) begin
      data_q <= ctrl_i.push_byte;
    end else if (ctrl_i.shift) begin
      data_q <= nbr_i;
    end
  end

  assign data_o = data_q;

endmodule

[rtl/core/byte_ring_fifo_with_search_unit.sv]
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_search_unit
// Byte FIFO built as a rotating ring of DEPTH cells. Outside a find or peek
// lap, cell 0 holds the oldest byte; push writes the cell at the fill level,
// pop and discard rotate the ring, find and peek rotate it once all the way round.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+------------------------------------------
//  in_i    | in  | valid / ready | func, data_byte, amount, position
//  out_o   | out | valid / ready | status, data_out, found_position,
//          |     |               | fill_level, last
//
//  Push, flush, unused codes, out-of-range find/peek: result registered from
//  the item. Pop of n bytes: n results, one per cycle and one ring rotate
//  each, the first loaded after the sequencer enters the pop state. Discard
//  of n bytes: result at once, then one rotate per byte before the next
//  item. Find/peek: a lap of DEPTH rotates, result loaded at the lap's end.
//  Reset clears level, sequencer and result valid only; cell bytes stay
//  undefined. A stalled result register holds the ring still during a pop.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_search_unit #(
  parameter int unsigned DEPTH   = 256,
  parameter int unsigned MAX_POP = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  brfs_in_if.sink     in_i,
  brfs_out_if.source  out_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (LW > brfs_pkg::AMT_W) ? LW : brfs_pkg::AMT_W;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_DISC = 2'd2;
  localparam logic [1:0] S_SCAN = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [LW-1:0] level_q, level_d;
  logic [LW-1:0] cnt_q, cnt_d;

  // scan operands and partial results
  logic                        is_find_q, is_find_d;
  logic [brfs_pkg::POS_W-1:0]  pos_q, pos_d;
  logic [brfs_pkg::BYTE_W-1:0] key_q, key_d;
  logic                        hit_q, hit_d;
  logic [brfs_pkg::POS_W-1:0]  hit_pos_q, hit_pos_d;
  logic [brfs_pkg::BYTE_W-1:0] peek_q, peek_d;

  // result register
  logic                        out_valid_q, out_valid_d;
  logic [brfs_pkg::STAT_W-1:0] out_status_q, out_status_d;
  logic [brfs_pkg::BYTE_W-1:0] out_data_q, out_data_d;
  logic [brfs_pkg::POS_W-1:0]  out_found_q, out_found_d;
  logic [brfs_pkg::FILL_W-1:0] out_fill_q, out_fill_d;
  logic                        out_last_q, out_last_d;
  logic                        out_ld;
  logic                        out_free;

  logic                        in_ready;
  logic                        in_acc;
  brfs_pkg::cell_ctrl_t        cell_ctrl;
  logic [brfs_pkg::BYTE_W-1:0] cell_data [DEPTH];

  // widened views for compares
  logic [CW-1:0] level_ext, level_d_ext, cnt_ext, amt_ext, in_pos_ext, pos_ext;
  logic [CW-1:0] pop_n, disc_n;
  logic          scan_end;
  logic          scan_at_pos;
  logic          find_now;

  assign level_ext   = CW'(level_q);
  assign level_d_ext = CW'(level_d);
  assign cnt_ext     = CW'(cnt_q);
  assign amt_ext     = CW'(in_i.amount);
  assign in_pos_ext  = CW'(in_i.position);
  assign pos_ext     = CW'(pos_q);

  // pop count: amount clamped to MAX_POP and to the level
  always_comb begin
    pop_n = amt_ext;
    if (pop_n > CW'(MAX_POP)) begin
      pop_n = CW'(MAX_POP);
    end
    if (pop_n > level_ext) begin
      pop_n = level_ext;
    end
  end

  assign disc_n = (amt_ext > level_ext) ? level_ext : amt_ext;

  // scan step: cell 0 holds the entry at offset cnt_q
  assign scan_end    = (cnt_q == LW'(DEPTH - 1));
  assign scan_at_pos = (cnt_ext == pos_ext);
  assign find_now    = !hit_q && (cnt_ext >= pos_ext) && (cnt_ext < level_ext) &&
                       (cell_data[0] == key_q);

  assign out_free = !out_valid_q || out_o.ready;
  assign in_ready = (state_q == S_IDLE) && out_free;
  assign in_acc   = in_i.valid && in_ready;

  // sequencer
  always_comb begin
    state_d      = state_q;
    level_d      = level_q;
    cnt_d        = cnt_q;
    is_find_d    = is_find_q;
    pos_d        = pos_q;
    key_d        = key_q;
    hit_d        = hit_q;
    hit_pos_d    = hit_pos_q;
    peek_d       = peek_q;
    out_ld       = 1'b0;
    out_status_d = brfs_pkg::STAT_OK;
    out_data_d   = '0;
    out_found_d  = '0;
    out_last_d   = 1'b1;
    cell_ctrl.shift     = 1'b0;
    cell_ctrl.push      = 1'b0;
    cell_ctrl.push_byte = in_i.data_byte;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          out_ld = 1'b1;
          unique case (in_i.func)
            brfs_pkg::FUNC_PUSH: begin
              if (level_ext >= CW'(DEPTH)) begin
                out_status_d = brfs_pkg::STAT_FULL;
              end else begin
                cell_ctrl.push = 1'b1;
                level_d        = level_q + LW'(1);
              end
            end
            brfs_pkg::FUNC_POP: begin
              if (level_q == '0) begin
                out_status_d = brfs_pkg::STAT_EMPTY;
              end else if (pop_n != '0) begin
                // results stream from the pop state
                out_ld  = 1'b0;
                level_d = level_q - pop_n[LW-1:0];
                cnt_d   = pop_n[LW-1:0];
                state_d = S_POP;
              end
            end
            brfs_pkg::FUNC_FLUSH: begin
              level_d = '0;
            end
            brfs_pkg::FUNC_DISCARD: begin
              level_d = level_q - disc_n[LW-1:0];
              if (disc_n != '0) begin
                cnt_d   = disc_n[LW-1:0];
                state_d = S_DISC;
              end
            end
            brfs_pkg::FUNC_FIND, brfs_pkg::FUNC_PEEK: begin
              if (in_pos_ext >= level_ext) begin
                out_status_d = brfs_pkg::STAT_RANGE;
              end else begin
                out_ld    = 1'b0;
                is_find_d = (in_i.func == brfs_pkg::FUNC_FIND);
                pos_d     = in_i.position;
                key_d     = in_i.data_byte;
                hit_d     = 1'b0;
                cnt_d     = '0;
                state_d   = S_SCAN;
              end
            end
            default: begin
              // unused codes: plain ok result
            end
          endcase
        end
      end

      S_POP: begin
        if (out_free) begin
          out_ld          = 1'b1;
          out_data_d      = cell_data[0];
          out_last_d      = (cnt_q == LW'(1));
          cell_ctrl.shift = 1'b1;
          cnt_d           = cnt_q - LW'(1);
          if (cnt_q == LW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end

      S_DISC: begin
        cell_ctrl.shift = 1'b1;
        cnt_d           = cnt_q - LW'(1);
        if (cnt_q == LW'(1)) begin
          state_d = S_IDLE;
        end
      end

      S_SCAN: begin
        cell_ctrl.shift = 1'b1;
        cnt_d           = cnt_q + LW'(1);
        if (find_now) begin
          hit_d     = 1'b1;
          hit_pos_d = cnt_ext[brfs_pkg::POS_W-1:0];
        end
        if (scan_at_pos) begin
          peek_d = cell_data[0];
        end
        if (scan_end) begin
          // full lap done, ring back in order
          out_ld  = 1'b1;
          state_d = S_IDLE;
          if (is_find_q) begin
            if (hit_q) begin
              out_found_d = hit_pos_q;
            end else if (find_now) begin
              out_found_d = cnt_ext[brfs_pkg::POS_W-1:0];
            end else begin
              out_status_d = brfs_pkg::STAT_EMPTY;
            end
          end else begin
            out_data_d = scan_at_pos ? cell_data[0] : peek_q;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_fill_d  = level_d_ext[brfs_pkg::FILL_W-1:0];
  assign out_valid_d = out_ld ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      level_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      level_q     <= level_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    is_find_q <= is_find_d;
    pos_q     <= pos_d;
    key_q     <= key_d;
    hit_q     <= hit_d;
    hit_pos_q <= hit_pos_d;
    peek_q    <= peek_d;
    if (out_ld) begin
      out_status_q <= out_status_d;
      out_data_q   <= out_data_d;
      out_found_q  <= out_found_d;
      out_fill_q   <= out_fill_d;
      out_last_q   <= out_last_d;
    end
  end

  // ring of cells, each fed by its upper neighbor
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    brfs_cell #(
      .AW  (AW),
      .IDX (k)
    ) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (cell_ctrl),
      .wr_idx_i (level_q[AW-1:0]),
      .nbr_i    (cell_data[(k + 1) % DEPTH]),
      .data_o   (cell_data[k])
    );
  end

  assign in_i.ready           = in_ready;
  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_status_q;
  assign out_o.data_out       = out_data_q;
  assign out_o.found_position = out_found_q;
  assign out_o.fill_level     = out_fill_q;
  assign out_o.last           = out_last_q;

  // level never passes the ring size
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LW'(DEPTH))
    else $error("fill level above depth");

  // a non-final result only exists while a pop streams
  a_mid_result_in_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_last_q) |-> (state_q == S_POP))
    else $error("non-final result outside pop");

  // result register is free when a scan lap completes
  a_scan_end_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && scan_end) |-> !out_valid_q)
    else $error("result register busy at scan end");

  // a completed scan returns to idle with a result pending
  a_scan_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && scan_end) |=> (state_q == S_IDLE && out_valid_q))
    else $error("scan did not finish");

endmodule
